>>> sv/mrq_pkg.sv
// ----------------------------------------------------------------------------
// mrq_pkg: shared types and constants of the message ring queue
// Field widths, request and status codes, and the byte mask used to cut a
// stored message down to its length.
// ----------------------------------------------------------------------------
package mrq_pkg;

  localparam int unsigned ModeW = 2;
  localparam int unsigned DataW = 64;
  localparam int unsigned LenW  = 4;
  localparam int unsigned StatW = 2;
  localparam int unsigned CfgW  = 5;
  localparam int unsigned CntW  = 32;

  // Ring size after reset
  localparam logic [CfgW-1:0] RingCfgRst = 5'd16;

  typedef enum logic [ModeW-1:0] {
    MODE_ENQ = 2'd0,
    MODE_DEQ = 2'd1,
    MODE_CLR = 2'd2
  } mode_e;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_TOOLONG = 2'd3
  } status_e;

  // Keep bytes below len, zero the rest
  function automatic logic [DataW-1:0] byte_mask(input logic [LenW-1:0] len);
    logic [DataW-1:0] m;
    m = '0;
    for (int b = 0; b < DataW / 8; b++) begin
      if (LenW'(b) < len) begin
        m[b*8 +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

>>> sv/mrq_req_if.sv
// ----------------------------------------------------------------------------
// mrq_req_if: request channel of the message ring queue
// Valid/ready channel carrying one request word: mode, message bytes, length.
// ----------------------------------------------------------------------------
interface mrq_req_if;
  import mrq_pkg::*;

  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [DataW-1:0] msg_data;
  logic [LenW-1:0]  msg_len;

  modport source(output valid, mode, msg_data, msg_len, input ready);
  modport sink(input valid, mode, msg_data, msg_len, output ready);

endinterface

>>> sv/mrq_rsp_if.sv
// ----------------------------------------------------------------------------
// mrq_rsp_if: result channel of the message ring queue
// Valid/ready channel carrying one result word: status, dequeued message and
// the four event counters.
// ----------------------------------------------------------------------------
interface mrq_rsp_if;
  import mrq_pkg::*;

  logic             valid;
  logic             ready;
  logic [StatW-1:0] status;
  logic [DataW-1:0] out_data;
  logic [LenW-1:0]  out_len;
  logic [CntW-1:0]  full_count;
  logic [CntW-1:0]  empty_count;
  logic [CntW-1:0]  accepted_count;
  logic [CntW-1:0]  delivered_count;

  modport source(output valid, status, out_data, out_len, full_count, empty_count,
                 accepted_count, delivered_count, input ready);
  modport sink(input valid, status, out_data, out_len, full_count, empty_count,
               accepted_count, delivered_count, output ready);

endinterface

>>> sv/message_ring_queue_with_stats_unit.sv
// Message ring queue with event counters. Each request word (enqueue, dequeue
// or clear pointers) is taken on acceptance and its result word appears on the
// next cycle from the output register; a new request is taken every cycle as
// long as the result side keeps up. The rate is set by the slot memories,
// which take one write and one registered read of the head slot per cycle.
// After reset the block zeroes every slot of the length memory and
// takes no request until that pass is done; ring size writes are taken at
// any time. The ring size is clamped to 2..MAX_SLOTS, and one slot
// always stays empty, so the capacity is the ring size minus one.
// ----------------------------------------------------------------------------
// message_ring_queue_with_stats_unit: circular message queue with statistics
// Head/tail pointer control, slot memories for data and length, a result
// register and four wrapping 32-bit event counters.
// ----------------------------------------------------------------------------
module message_ring_queue_with_stats_unit #(
  parameter int unsigned MAX_SLOTS = 16,
  parameter int unsigned MSG_BYTES = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mrq_pkg::CfgW-1:0] cfg_wdata_i,
  mrq_req_if.sink                  req_i,
  mrq_rsp_if.source                rsp_o
);
  import mrq_pkg::*;

  localparam int unsigned PtrW = $clog2(MAX_SLOTS);
  localparam int unsigned SzW  = ((PtrW > CfgW) ? PtrW : CfgW) + 1;
  localparam int unsigned MsgW = 8 * MSG_BYTES;
  localparam logic [SzW-1:0]  MaxSz    = SzW'(MAX_SLOTS);
  localparam logic [SzW-1:0]  MinSz    = SzW'(2);
  localparam logic [LenW-1:0] MaxLen   = LenW'(MSG_BYTES);
  localparam logic [PtrW-1:0] LastSlot = PtrW'(MAX_SLOTS - 1);

  // Slot memories
  logic [MsgW-1:0] data_mem [MAX_SLOTS];
  logic [LenW-1:0] len_mem  [MAX_SLOTS];

  // Control and counter state
  logic [CfgW-1:0] ring_cfg_q;
  logic [PtrW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0] full_cnt_q, full_cnt_d;
  logic [CntW-1:0] empty_cnt_q, empty_cnt_d;
  logic [CntW-1:0] acc_cnt_q, acc_cnt_d;
  logic [CntW-1:0] dlv_cnt_q, dlv_cnt_d;
  logic            clr_busy_q;
  logic [PtrW-1:0] clr_idx_q;

  // Result register
  logic            rsp_valid_q, rsp_valid_d;
  status_e         status_q, status_d;
  logic            deq_q;
  logic [MsgW-1:0] rd_data_q;
  logic [LenW-1:0] rd_len_q;

  logic            accept;
  logic            enq_ok, deq_ok;
  logic [SzW-1:0]  cfg_ext, ring_sz;
  logic [SzW-1:0]  head_inc, tail_inc;
  logic [PtrW-1:0] head_nxt, tail_nxt;
  logic            q_full, q_empty;
  logic [DataW-1:0] len_mask;

  // Hold requests off during the clearing pass and while a result waits
  assign req_i.ready = !clr_busy_q && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // Clamp the ring size
  always_comb begin
    cfg_ext = SzW'(ring_cfg_q);
    if (cfg_ext < MinSz) begin
      ring_sz = MinSz;
    end else if (cfg_ext > MaxSz) begin
      ring_sz = MaxSz;
    end else begin
      ring_sz = cfg_ext;
    end
  end

  // Advance pointers with wrap at the ring size
  always_comb begin
    head_inc = SzW'(head_q) + SzW'(1);
    tail_inc = SzW'(tail_q) + SzW'(1);
    head_nxt = (head_inc >= ring_sz) ? '0 : head_inc[PtrW-1:0];
    tail_nxt = (tail_inc >= ring_sz) ? '0 : tail_inc[PtrW-1:0];
    q_full   = (tail_nxt == head_q);
    q_empty  = (head_q == tail_q);
  end

  // Decode the request and update pointers and counters
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    full_cnt_d  = full_cnt_q;
    empty_cnt_d = empty_cnt_q;
    acc_cnt_d   = acc_cnt_q;
    dlv_cnt_d   = dlv_cnt_q;
    status_d    = ST_OK;
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    if (accept) begin
      case (mode_e'(req_i.mode))
        MODE_ENQ: begin
          if (req_i.msg_len > MaxLen) begin
            status_d = ST_TOOLONG;
          end else if (q_full) begin
            status_d   = ST_FULL;
            full_cnt_d = full_cnt_q + CntW'(1);
          end else begin
            enq_ok    = 1'b1;
            tail_d    = tail_nxt;
            acc_cnt_d = acc_cnt_q + CntW'(1);
          end
        end
        MODE_DEQ: begin
          if (q_empty) begin
            status_d    = ST_EMPTY;
            empty_cnt_d = empty_cnt_q + CntW'(1);
          end else begin
            deq_ok    = 1'b1;
            head_d    = head_nxt;
            dlv_cnt_d = dlv_cnt_q + CntW'(1);
          end
        end
        MODE_CLR: begin
          head_d = '0;
          tail_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Raise result valid on accept, drop it once taken
  always_comb begin
    if (accept) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_cfg_q  <= RingCfgRst;
      head_q      <= '0;
      tail_q      <= '0;
      full_cnt_q  <= '0;
      empty_cnt_q <= '0;
      acc_cnt_q   <= '0;
      dlv_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ring_cfg_q <= cfg_wdata_i;
      end
      head_q      <= head_d;
      tail_q      <= tail_d;
      full_cnt_q  <= full_cnt_d;
      empty_cnt_q <= empty_cnt_d;
      acc_cnt_q   <= acc_cnt_d;
      dlv_cnt_q   <= dlv_cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Sweep the length memory to zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_idx_q == LastSlot) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_idx_q <= clr_idx_q + PtrW'(1);
      end
    end
  end

  // Capture result status
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      deq_q    <= deq_ok;
    end
  end

  // Data memory: write at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (enq_ok) begin
      data_mem[tail_q] <= req_i.msg_data[MsgW-1:0];
    end
    if (accept) begin
      rd_data_q <= data_mem[head_q];
    end
  end

  // Length memory: clear sweep, write on enqueue, zero on dequeue
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      len_mem[clr_idx_q] <= '0;
    end else if (enq_ok) begin
      len_mem[tail_q] <= req_i.msg_len;
    end else if (deq_ok) begin
      len_mem[head_q] <= '0;
    end
    if (accept) begin
      rd_len_q <= len_mem[head_q];
    end
  end

  // Drive the result word; cut the message to its length
  assign len_mask = byte_mask(rd_len_q);

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = status_q;
  assign rsp_o.out_len         = deq_q ? rd_len_q : '0;
  assign rsp_o.out_data        = deq_q ? DataW'(rd_data_q & len_mask[MsgW-1:0]) : '0;
  assign rsp_o.full_count      = full_cnt_q;
  assign rsp_o.empty_count     = empty_cnt_q;
  assign rsp_o.accepted_count  = acc_cnt_q;
  assign rsp_o.delivered_count = dlv_cnt_q;

endmodule
